// File: rtl/core/cbpg_pkg.sv
// ---------------------------------------------------------------------------
// cbpg_pkg
// Shared types for the cubic Bezier point generator and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package cbpg_pkg;

	// Signed Q12.4 coordinate
	typedef logic signed [15:0] coord_t;

	// One sampled point as it travels down the pipeline
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} point_t;

endpackage

`default_nettype wire

// File: rtl/core/cubic_bezier_point_generator.sv
// ---------------------------------------------------------------------------
// cubic_bezier_point_generator
// De Casteljau evaluation of a cubic curve at t = k / 2^STEP_BITS.
// ---------------------------------------------------------------------------
// A curve (four control points) is taken when start is high and busy is low.
// The block then emits 2^STEP_BITS + 1 points, k = 0 up to 2^STEP_BITS, one
// per cycle on point_x/point_y with strobe high; the point at k = 2^STEP_BITS
// carries last_point. The first point reaches the ports from the three
// interpolation stages behind the capture register. The step counter sets the
// rate: busy drops in the cycle that issues the last step, so the next curve
// can be taken then and runs follow with no gap. There is no backpressure:
// the receiver must take every word in the cycle its strobe is high.
// ---------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_generator
	import cbpg_pkg::*;
#(
	parameter int STEP_BITS = 5
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire coord_t start_x,
	input  wire coord_t start_y,
	input  wire coord_t ctrl1_x,
	input  wire coord_t ctrl1_y,
	input  wire coord_t ctrl2_x,
	input  wire coord_t ctrl2_y,
	input  wire coord_t end_x,
	input  wire coord_t end_y,
	output logic        strobe,
	output coord_t      point_x,
	output coord_t      point_y,
	output logic        last_point
);

	localparam int STEPS = 1 << STEP_BITS;
	localparam int KW    = STEP_BITS + 1;
	localparam int PW    = 18 + KW;
	localparam logic [KW-1:0] K_LAST = KW'(STEPS);

	// p + floor(k * (q - p) / 2^STEP_BITS); result always lies between p and q
	function automatic coord_t lerp(coord_t p, coord_t q, logic [KW-1:0] k);
		logic signed [16:0]   d;
		logic signed [PW-1:0] prod;
		logic signed [PW-1:0] sh;
		d    = {q[15], q} - {p[15], p};
		prod = PW'(d) * PW'($signed({1'b0, k}));
		sh   = prod >>> STEP_BITS;
		return p + sh[15:0];
	endfunction

	// Curve capture and step counter
	coord_t        ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
	logic [KW-1:0] k_q;
	logic          active_q;
	logic          accept;
	logic          k_is_last;

	assign k_is_last = (k_q == K_LAST);
	assign busy      = active_q & ~k_is_last;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			k_q      <= '0;
		end else if (active_q) begin
			// drop out after the last step
			active_q <= ~k_is_last;
			k_q      <= k_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= start_x;
			ay_q <= start_y;
			bx_q <= ctrl1_x;
			by_q <= ctrl1_y;
			cx_q <= ctrl2_x;
			cy_q <= ctrl2_y;
			dx_q <= end_x;
			dy_q <= end_y;
		end
	end

	// Stage 1: first-level interpolations
	logic          valid_s1;
	logic          last_s1;
	logic [KW-1:0] k_s1;
	coord_t        abx_s1, aby_s1, bcx_s1, bcy_s1, cdx_s1, cdy_s1;

	// Stage 2: second-level interpolations
	logic          valid_s2;
	logic          last_s2;
	logic [KW-1:0] k_s2;
	coord_t        abcx_s2, abcy_s2, bcdx_s2, bcdy_s2;

	// Stage 3: curve point
	logic          valid_s3;
	point_t        pt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= active_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		last_s1 <= k_is_last;
		abx_s1  <= lerp(ax_q, bx_q, k_q);
		aby_s1  <= lerp(ay_q, by_q, k_q);
		bcx_s1  <= lerp(bx_q, cx_q, k_q);
		bcy_s1  <= lerp(by_q, cy_q, k_q);
		cdx_s1  <= lerp(cx_q, dx_q, k_q);
		cdy_s1  <= lerp(cy_q, dy_q, k_q);

		k_s2    <= k_s1;
		last_s2 <= last_s1;
		abcx_s2 <= lerp(abx_s1, bcx_s1, k_s1);
		abcy_s2 <= lerp(aby_s1, bcy_s1, k_s1);
		bcdx_s2 <= lerp(bcx_s1, cdx_s1, k_s1);
		bcdy_s2 <= lerp(bcy_s1, cdy_s1, k_s1);

		pt_s3.x    <= lerp(abcx_s2, bcdx_s2, k_s2);
		pt_s3.y    <= lerp(abcy_s2, bcdy_s2, k_s2);
		pt_s3.last <= last_s2;
	end

	assign strobe     = valid_s3;
	assign point_x    = pt_s3.x;
	assign point_y    = pt_s3.y;
	assign last_point = valid_s3 & pt_s3.last;

endmodule

`default_nettype wire

// File: rtl/core/cbpg_checker.sv
// ---------------------------------------------------------------------------
// cbpg_checker
// Port-level timing checks for the cubic Bezier point generator.
// ---------------------------------------------------------------------------
`default_nettype none

module cbpg_checker
	import cbpg_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   start,
	input wire logic   busy,
	input wire coord_t start_x,
	input wire coord_t start_y,
	input wire logic   strobe,
	input wire coord_t point_x,
	input wire coord_t point_y,
	input wire logic   last_point
);

	logic accept;
	assign accept = start & ~busy;

	// A flagged word is always a real word
	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_point |-> strobe)
		else $error("last_point without strobe");

	// While busy, the step being issued leaves the pipe as a non-final word
	a_busy_feeds_output: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ##3 (strobe && !last_point))
		else $error("busy step did not produce a word");

	// The first word of a run is the start point captured at accept
	a_first_point: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 (strobe && !last_point &&
			point_x == $past(start_x, 4) && point_y == $past(start_y, 4)))
		else $error("first point of run is not the start point");

endmodule

bind cubic_bezier_point_generator cbpg_checker u_cbpg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.start_x    (start_x),
	.start_y    (start_y),
	.strobe     (strobe),
	.point_x    (point_x),
	.point_y    (point_y),
	.last_point (last_point)
);

`default_nettype wire

// File: tb/tb_cubic_bezier_point_generator.sv
// ---------------------------------------------------------------------------
// tb_cubic_bezier_point_generator
// Self-checking bench for the cubic Bezier point generator.
// ---------------------------------------------------------------------------
// Curves are queued up front, a directed set first and then random ones.
// A clocked driver sends them in bursts with random gaps. On every accepted
// curve, the bench evaluates the de Casteljau scheme at each step k with
// floor rounding and queues the expected points. A clocked monitor checks
// every strobed word against the oldest expected point, field by field.
// ---------------------------------------------------------------------------

module tb_cubic_bezier_point_generator;
	import cbpg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEP_BITS   = 5;
	localparam int STEPS       = 1 << STEP_BITS;
	localparam int RANDOM_CNT  = 93;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		coord_t ax, ay, bx, by, cx, cy, dx, dy;
	} curve_t;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	logic   busy;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t ctrl1_x = '0;
	coord_t ctrl1_y = '0;
	coord_t ctrl2_x = '0;
	coord_t ctrl2_y = '0;
	coord_t end_x   = '0;
	coord_t end_y   = '0;
	logic   strobe;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;

	curve_t curve_backlog[$];
	point_t expected_points[$];
	curve_t driven_curve;
	point_t want;

	int gap_left     = 0;
	int burst_left   = 1;
	int cycles       = 0;
	int errors       = 0;
	int curves_sent  = 0;
	int points_seen  = 0;
	int runs_closed  = 0;

	cubic_bezier_point_generator #(
		.STEP_BITS(STEP_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.start_x   (start_x),
		.start_y   (start_y),
		.ctrl1_x   (ctrl1_x),
		.ctrl1_y   (ctrl1_y),
		.ctrl2_x   (ctrl2_x),
		.ctrl2_y   (ctrl2_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.strobe    (strobe),
		.point_x   (point_x),
		.point_y   (point_y),
		.last_point(last_point)
	);

	always #5 clk = ~clk;

	// p + floor(k * (q - p) / 2^STEP_BITS); arithmetic shift floors negatives
	function automatic int lerp_floor(int p, int q, int k);
		int prod;
		prod = k * (q - p);
		return p + (prod >>> STEP_BITS);
	endfunction

	function automatic coord_t bezier_axis(coord_t a, coord_t b, coord_t c, coord_t d, int k);
		int ab, bc, cd, abc, bcd;
		ab  = lerp_floor(a, b, k);
		bc  = lerp_floor(b, c, k);
		cd  = lerp_floor(c, d, k);
		abc = lerp_floor(ab, bc, k);
		bcd = lerp_floor(bc, cd, k);
		return coord_t'(lerp_floor(abc, bcd, k));
	endfunction

	function automatic void predict_points(curve_t cv);
		point_t pt;
		for (int k = 0; k <= STEPS; k++) begin
			pt.x    = bezier_axis(cv.ax, cv.bx, cv.cx, cv.dx, k);
			pt.y    = bezier_axis(cv.ay, cv.by, cv.cy, cv.dy, k);
			pt.last = (k == STEPS);
			expected_points.push_back(pt);
		end
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			1: return coord_t'(int'($urandom_range(0, 63)) - 32);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic add_curve(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, coord_t dx, coord_t dy);
		curve_t cv;
		cv = '{ax, ay, bx, by, cx, cy, dx, dy};
		curve_backlog.push_back(cv);
	endtask

	always @(posedge clk) cycles <= cycles + 1;

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Driver: hold a word until taken, then advance or idle per the burst plan
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_points(driven_curve);
				curves_sent <= curves_sent + 1;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start    <= 1'b0;
				end else if (curve_backlog.size() > 0) begin
					driven_curve = curve_backlog.pop_front();
					start_x <= driven_curve.ax;
					start_y <= driven_curve.ay;
					ctrl1_x <= driven_curve.bx;
					ctrl1_y <= driven_curve.by;
					ctrl2_x <= driven_curve.cx;
					ctrl2_y <= driven_curve.cy;
					end_x   <= driven_curve.dx;
					end_y   <= driven_curve.dy;
					start   <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 8);
						gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 80);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed word must match the oldest expected point
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d last=%0b",
					$time, point_x, point_y, last_point);
				errors <= errors + 1;
			end else begin
				want = expected_points.pop_front();
				points_seen <= points_seen + 1;
				if (last_point) runs_closed <= runs_closed + 1;
				if (point_x !== want.x || point_y !== want.y || last_point !== want.last) begin
					if (point_x !== want.x)
						$display("%0t: point_x expected %0d actual %0d", $time, want.x, point_x);
					if (point_y !== want.y)
						$display("%0t: point_y expected %0d actual %0d", $time, want.y, point_y);
					if (last_point !== want.last)
						$display("%0t: last_point expected %0b actual %0b",
							$time, want.last, last_point);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		curve_t cv;
		int mode;
		int per_value;

		// Directed: extremes, full-span differences, floor on negatives
		add_curve(0, 0, 0, 0, 0, 0, 0, 0);
		add_curve(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		add_curve(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		add_curve(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		add_curve(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		add_curve(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		add_curve(0, 0, 0, 0, 0, 0, -1, -1);
		add_curve(-1, -1, 0, 0, 0, 0, 0, 0);
		add_curve(0, 0, -1, 1, 1, -1, 0, 0);
		add_curve(5, -5, 3, -3, 1, -1, -7, 7);
		add_curve(-100, 100, -33, 33, 33, -33, 100, -100);
		add_curve(1234, -4321, 1234, -4321, 1234, -4321, 1234, -4321);
		add_curve(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
			16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
		add_curve(16'sh0001, 16'sh8000, 16'sh0100, 16'sh0080,
			16'sh4000, 16'sh0002, 16'sh0010, 16'sh2000);
		add_curve(16'sh00ff, 16'shff00, 16'sh0f0f, 16'shf0f0,
			16'sh3333, 16'shcccc, 16'sh7ffe, 16'sh8001);
		add_curve(0, 0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 0);
		add_curve(16'sh0010, 16'shfff0, 16'sh0020, 16'shffe0,
			16'sh0030, 16'shffd0, 16'sh0040, 16'shffc0);

		for (int i = 0; i < RANDOM_CNT; i++) begin
			mode = $urandom_range(0, 9);
			per_value = (mode < 6) ? 0 : (mode < 8) ? 1 : (mode == 8) ? 2 : -1;
			cv.ax = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.ay = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.bx = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.by = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.cx = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.cy = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.dx = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			cv.dy = rand_coord(per_value < 0 ? $urandom_range(0, 2) : per_value);
			curve_backlog.push_back(cv);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all curves taken, all points seen, then a quiet tail
		@(posedge clk);
		while (curve_backlog.size() != 0 || start || expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d curves, checked %0d points over %0d closed runs, %0d mismatches.",
			curves_sent, points_seen, runs_closed, errors);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/cbpg_pkg.sv
rtl/core/cubic_bezier_point_generator.sv
rtl/core/cbpg_checker.sv
tb/tb_cubic_bezier_point_generator.sv
